>>> rtl/poly_voice_allocator_macros.svh
// Assertion macros for the voice allocator.
`ifndef POLY_VOICE_ALLOCATOR_MACROS_SVH
`define POLY_VOICE_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define PVA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pva assertion failed");
`define PVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pva assertion failed");
`else
`define PVA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PVA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/pva_pkg.sv
// Shared types and constants of the voice allocator.
package pva_pkg;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_ALL_OFF  = 2'd2
    } t_op;

    localparam logic [6:0] VEL_FLOOR = 7'd6;
    localparam logic [7:0] LOW_NONE  = 8'hFF;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] note;
        logic [6:0] velocity;
        logic [7:0] sounding;
    } t_cmd;

    typedef struct packed {
        logic       busy;
        logic [2:0] voice_index;
        logic       snap;
        logic [7:0] release_mask;
    } t_voice_res;

    typedef struct packed {
        logic       busy;
        logic [4:0] held_total;
        logic [7:0] lowest_note;
    } t_held_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN
    } t_top_state;

    typedef enum logic [1:0] {
        V_IDLE,
        V_SCAN,
        V_COMMIT
    } t_voice_state;

    typedef enum logic {
        H_IDLE,
        H_SCAN
    } t_held_state;

endpackage

>>> rtl/poly_voice_allocator.sv
// Top level of the polyphonic voice allocator: stream ports, sequencer, result register.
// Usage:
// Events enter on the s_ channel: s_tuser holds the operation (note on, note off,
// all notes off), s_tdata the note, velocity and sounding mask. One result per
// event leaves on the m_ channel; m_tuser flags a newly gated voice.
// The glide bit is written on the cfg channel; the user must write it only while
// no event is in flight; the block does not enforce this. o_cfg_ready is always high.
// A note on result waits for the serial voice scan (one voice per cycle through
// one age comparator) plus the commit step; a note off result waits for the voice
// scan or the held-list compaction through its single read port, whichever ends
// later; all notes off and unused codes wait for neither.
// One event is processed at a time; s_tready is low from accept until the result
// is loaded into the output register.
// The output register holds a result while m_tready is low; the next event may
// be accepted meanwhile, and its result waits inside until the register frees.
// Reset clears the held list, voice state, age counter and glide bit; no
// clearing pass is needed.
`include "poly_voice_allocator_macros.svh"
module poly_voice_allocator
    import pva_pkg::*;
#(
    parameter int NUM_VOICES = 8,
    parameter int HELD_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_data,   // glide_enabled
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,      // note[6:0], velocity[13:7], sounding_mask[21:14], zero
    input  logic [1:0]  s_tuser,      // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // voice_index, snap_pitch, voice_velocity,
                                      // release_mask, held_total, lowest_note
    output logic [0:0]  m_tuser       // voice_valid
);

    t_top_state r_state;
    t_top_state n_state;
    logic       r_glide;
    t_op        r_op;
    logic [6:0] r_vel;
    logic       r_mvalid;
    logic [31:0] r_mdata;
    logic       r_muser;

    t_cmd       w_cmd;
    logic       w_accept;
    logic       w_done;
    logic       w_load;
    logic [6:0] w_ovel;
    t_voice_res w_vres;
    t_held_res  w_hres;

    assign w_cmd.op       = s_tuser;
    assign w_cmd.note     = s_tdata[6:0];
    assign w_cmd.velocity = s_tdata[13:7];
    assign w_cmd.sounding = s_tdata[21:14];

    assign s_tready = (r_state == ST_IDLE);
    assign w_accept = s_tvalid && s_tready;
    assign w_done   = (r_state == ST_RUN) && !w_vres.busy && !w_hres.busy;
    assign w_load   = w_done && (!r_mvalid || m_tready);

    pva_voice_table #(
        .NUM_VOICES(NUM_VOICES)
    ) u_voice (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_accept),
        .i_cmd  (w_cmd),
        .i_glide(r_glide),
        .o_res  (w_vres)
    );

    pva_held_list #(
        .HELD_DEPTH(HELD_DEPTH)
    ) u_held (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_accept),
        .i_cmd  (w_cmd),
        .o_res  (w_hres)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glide <= 1'b0;
        end else if (i_cfg_valid) begin
            r_glide <= i_cfg_data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= t_op'(s_tuser);
            r_vel <= s_tdata[13:7];
        end
    end

    assign w_ovel = ((r_op == OP_NOTE_ON) && (r_vel > VEL_FLOOR)) ? r_vel : VEL_FLOOR;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (w_load) begin
            r_mvalid <= 1'b1;
        end else if (m_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_muser <= (r_op == OP_NOTE_ON);
            r_mdata <= {w_hres.lowest_note, w_hres.held_total, w_vres.release_mask,
                        w_ovel, w_vres.snap, w_vres.voice_index};
        end
    end

    assign m_tvalid   = r_mvalid;
    assign m_tdata    = r_mdata;
    assign m_tuser[0] = r_muser;

    `PVA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !s_tready)
    `PVA_ASSERT_SAME(a_vel_floor, i_clk, i_rst_n, m_tvalid, m_tdata[10:4] >= VEL_FLOOR)
    `PVA_ASSERT_SAME(a_idle_result, i_clk, i_rst_n, m_tvalid && !m_tuser[0],
                     (m_tdata[2:0] == 3'd0) && !m_tdata[3])

endmodule

>>> rtl/pva_held_list.sv
// Held-note list: append, serial compaction on note off, lowest-note tracking.
module pva_held_list
    import pva_pkg::*;
#(
    parameter int HELD_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_cmd      i_cmd,
    output t_held_res o_res
);

    localparam int CW = $clog2(HELD_DEPTH + 1);
    localparam int AW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(HELD_DEPTH);

    logic [6:0]    r_mem [HELD_DEPTH];
    logic [6:0]    r_q;
    logic          r_pv;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_ri;
    logic [CW-1:0] r_wi;
    logic [6:0]    r_min;
    logic          r_has;
    logic [6:0]    r_note;
    t_held_state   r_state;
    t_held_state   n_state;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [6:0]    w_wdata;
    logic          w_append;
    logic          w_keep;
    logic          w_scan_end;

    assign w_append   = i_start && (t_op'(i_cmd.op) == OP_NOTE_ON) && (r_cnt < DEPTH_C);
    assign w_keep     = (r_state == H_SCAN) && r_pv && (r_q != r_note);
    assign w_scan_end = (r_state == H_SCAN) && (r_ri == r_cnt) && !r_pv;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            H_IDLE: begin
                if (i_start && (t_op'(i_cmd.op) == OP_NOTE_OFF)) begin
                    n_state = H_SCAN;
                end
            end
            H_SCAN: begin
                if (w_scan_end) begin
                    n_state = H_IDLE;
                end
            end
            default: n_state = H_IDLE;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt[AW-1:0];
        w_wdata = i_cmd.note;
        if (w_append) begin
            w_we = 1'b1;
        end else if (w_keep) begin
            w_we    = 1'b1;
            w_waddr = r_wi[AW-1:0];
            w_wdata = r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if ((r_state == H_SCAN) && (r_ri != r_cnt)) begin
            r_q <= r_mem[r_ri[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_has <= 1'b0;
            r_pv  <= 1'b0;
            r_ri  <= '0;
            r_wi  <= '0;
        end else if (r_state == H_IDLE) begin
            if (i_start) begin
                case (t_op'(i_cmd.op))
                    OP_NOTE_ON: begin
                        if (w_append) begin
                            r_cnt <= r_cnt + 1'b1;
                            if (!r_has || (i_cmd.note < r_min)) begin
                                r_min <= i_cmd.note;
                                r_has <= 1'b1;
                            end
                        end
                    end
                    OP_NOTE_OFF: begin
                        r_note <= i_cmd.note;
                        r_ri   <= '0;
                        r_wi   <= '0;
                        r_pv   <= 1'b0;
                        r_has  <= 1'b0;
                    end
                    OP_ALL_OFF: begin
                        r_cnt <= '0;
                        r_has <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end else begin
            // advance read side, check the entry read last cycle
            if (r_ri != r_cnt) begin
                r_ri <= r_ri + 1'b1;
                r_pv <= 1'b1;
            end else begin
                r_pv <= 1'b0;
            end
            if (w_keep) begin
                r_wi <= r_wi + 1'b1;
                if (!r_has || (r_q < r_min)) begin
                    r_min <= r_q;
                    r_has <= 1'b1;
                end
            end
            if (w_scan_end) begin
                r_cnt <= r_wi;
            end
        end
    end

    assign o_res.busy        = (r_state != H_IDLE);
    assign o_res.held_total  = 5'(r_cnt);
    assign o_res.lowest_note = r_has ? {1'b0, r_min} : LOW_NONE;

endmodule

>>> rtl/pva_voice_table.sv
// Voice table with serial free/oldest scan, age stamping and release.
module pva_voice_table
    import pva_pkg::*;
#(
    parameter int NUM_VOICES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_cmd       i_cmd,
    input  logic       i_glide,
    output t_voice_res o_res
);

    localparam int VW = $clog2(NUM_VOICES);
    localparam logic [VW-1:0] LAST_V = VW'(NUM_VOICES - 1);
    localparam logic [7:0] ALL_REL =
        (NUM_VOICES >= 8) ? 8'hFF : 8'((1 << NUM_VOICES) - 1);

    logic [NUM_VOICES-1:0] r_in_use;
    logic [6:0]            r_vnote [NUM_VOICES];
    logic [31:0]           r_vage  [NUM_VOICES];
    logic [31:0]           r_age_ctr;
    logic [VW-1:0]         r_vi;
    t_op                   r_op;
    logic [6:0]            r_note;
    logic [7:0]            r_snd;
    logic                  r_found;
    logic [VW-1:0]         r_free_idx;
    logic [VW-1:0]         r_best_idx;
    logic [31:0]           r_best_age;
    logic [VW-1:0]         r_idx;
    logic                  r_snap;
    logic [7:0]            r_rel;
    t_voice_state          r_state;
    t_voice_state          n_state;

    logic          w_in8;
    logic [2:0]    w_lo3;
    logic          w_sounding;
    logic [VW-1:0] w_slot;
    logic [31:0]   w_age_next;

    assign w_in8      = (32'(r_vi) < 32'd8);
    assign w_lo3      = 3'(r_vi);
    assign w_sounding = w_in8 && r_snd[w_lo3];
    assign w_slot     = r_found ? r_free_idx : r_best_idx;
    assign w_age_next = r_age_ctr + 32'd1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            V_IDLE: begin
                if (i_start && ((t_op'(i_cmd.op) == OP_NOTE_ON) ||
                                (t_op'(i_cmd.op) == OP_NOTE_OFF))) begin
                    n_state = V_SCAN;
                end
            end
            V_SCAN: begin
                if (r_vi == LAST_V) begin
                    n_state = (r_op == OP_NOTE_ON) ? V_COMMIT : V_IDLE;
                end
            end
            V_COMMIT: n_state = V_IDLE;
            default:  n_state = V_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= V_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use  <= '0;
            r_age_ctr <= '0;
            r_idx     <= '0;
            r_snap    <= 1'b0;
            r_rel     <= '0;
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_vnote[i] <= '0;
                r_vage[i]  <= '0;
            end
        end else begin
            unique case (r_state)
                V_IDLE: begin
                    if (i_start) begin
                        r_op       <= t_op'(i_cmd.op);
                        r_note     <= i_cmd.note;
                        r_snd      <= i_cmd.sounding;
                        r_vi       <= '0;
                        r_found    <= 1'b0;
                        r_free_idx <= '0;
                        r_best_idx <= '0;
                        r_best_age <= '1;
                        r_idx      <= '0;
                        r_snap     <= 1'b0;
                        r_rel      <= '0;
                        if (t_op'(i_cmd.op) == OP_ALL_OFF) begin
                            r_in_use <= '0;
                            r_rel    <= ALL_REL;
                        end
                    end
                end
                V_SCAN: begin
                    if (r_op == OP_NOTE_ON) begin
                        if (!r_found && !w_sounding && !r_in_use[r_vi]) begin
                            r_found    <= 1'b1;
                            r_free_idx <= r_vi;
                        end
                        if (r_vage[r_vi] < r_best_age) begin
                            r_best_age <= r_vage[r_vi];
                            r_best_idx <= r_vi;
                        end
                    end else if (r_in_use[r_vi] && (r_vnote[r_vi] == r_note)) begin
                        r_in_use[r_vi] <= 1'b0;
                        if (w_in8) begin
                            r_rel[w_lo3] <= 1'b1;
                        end
                    end
                    if (r_vi != LAST_V) begin
                        r_vi <= r_vi + 1'b1;
                    end
                end
                V_COMMIT: begin
                    r_snap           <= !r_in_use[w_slot] || !i_glide;
                    r_in_use[w_slot] <= 1'b1;
                    r_vnote[w_slot]  <= r_note;
                    r_vage[w_slot]   <= w_age_next;
                    r_age_ctr        <= w_age_next;
                    r_idx            <= w_slot;
                end
                default: ;
            endcase
        end
    end

    assign o_res.busy         = (r_state != V_IDLE);
    assign o_res.voice_index  = 3'(r_idx);
    assign o_res.snap         = r_snap;
    assign o_res.release_mask = r_rel;

endmodule
